>>> src/newton_fractal_cubic_pixel_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Newton fractal pixel unit
// Shared property wrappers, sampled on the rising clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef NEWTON_FRACTAL_CUBIC_PIXEL_UNIT_ASSERT_SVH
`define NEWTON_FRACTAL_CUBIC_PIXEL_UNIT_ASSERT_SVH

// same-cycle implication
`define NFC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/nfc_pkg.sv
// ----------------------------------------------------------------------------
// nfc_pkg
// Shared types and codes for the Newton fractal pixel unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfc_pkg;

  // control bits that travel with each pipeline slot
  typedef struct packed {
    logic valid;
    logic dead;   // zero derivative seen, pixel goes to root 0
  } nfc_ctl_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd1;

  // fixed widths of the register fields
  localparam int ORIGIN_W = 32;
  localparam int STEP_W   = 31;
  // register values: origin is signed Q4.28, step is unsigned Q3.28
  localparam int CFG_FRAC = 28;

  // root codes
  localparam logic [1:0] ROOT_ONE = 2'd0;
  localparam logic [1:0] ROOT_UP  = 2'd1;
  localparam logic [1:0] ROOT_DN  = 2'd2;

  localparam logic [7:0] COLOR_FULL = 8'hFF;
  localparam logic [7:0] COLOR_NONE = 8'h00;

  // reset values of the registers
  localparam logic signed [ORIGIN_W-1:0] ORIGIN_RST = -32'sd268435456;
  localparam logic [STEP_W-1:0]          STEP_RST   = 31'd131072;

endpackage

>>> src/nfc_map.sv
// ----------------------------------------------------------------------------
// nfc_map
// Maps pixel coordinates to plane coordinates: origin + step * coord,
// then moves Q4.28 to the working format with saturation. Two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfc_map #(
  parameter int FRAC_BITS  = 28,
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid_i,
  input  logic [COORD_BITS-1:0]                  x_coord_i,
  input  logic [COORD_BITS-1:0]                  y_coord_i,
  input  logic signed [nfc_pkg::ORIGIN_W-1:0]    origin_i,
  input  logic [nfc_pkg::STEP_W-1:0]             step_i,
  output nfc_pkg::nfc_ctl_t                      ctl_o,
  output logic signed [FRAC_BITS+3:0]            x_o,
  output logic signed [FRAC_BITS+3:0]            y_o
);

  localparam int W   = FRAC_BITS + 4;
  localparam int PXW = nfc_pkg::STEP_W + COORD_BITS;
  localparam int TW  = PXW + 2;
  localparam int SV  = (FRAC_BITS >= nfc_pkg::CFG_FRAC) ?
                       TW + FRAC_BITS - nfc_pkg::CFG_FRAC : TW;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic              vld_r;
  logic [COORD_BITS-1:0] coord [2];
  logic signed [W-1:0]   res_nxt [2];
  logic signed [W-1:0]   res_r [2];

  assign coord[0] = x_coord_i;
  assign coord[1] = y_coord_i;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [PXW-1:0]       px;
    logic signed [TW-1:0] t_nxt;
    logic signed [TW-1:0] t_r;
    logic signed [SV-1:0] v;

    // stage 1: origin + step * coord, exact
    assign px    = PXW'(step_i) * PXW'(coord[l]);
    assign t_nxt = TW'(origin_i) + $signed({2'b00, px});

    always_ff @(posedge clk) begin
      t_r <= t_nxt;
    end

    // stage 2: format change
    if (FRAC_BITS >= nfc_pkg::CFG_FRAC) begin : g_up
      assign v = SV'(t_r) <<< (FRAC_BITS - nfc_pkg::CFG_FRAC);
    end else begin : g_dn
      localparam int DN = nfc_pkg::CFG_FRAC - FRAC_BITS;
      logic [TW-1:0] mag;
      logic [TW-1:0] rnd;
      // round half away from zero on the magnitude
      assign mag = t_r[TW-1] ? TW'(-t_r) : TW'(t_r);
      assign rnd = (mag + (TW'(1) << (DN - 1))) >> DN;
      assign v   = t_r[TW-1] ? -$signed(rnd) : $signed(rnd);
    end

    assign res_nxt[l] = (v > SV'(VMAX)) ? VMAX :
                        (v < SV'(VMIN)) ? VMIN : v[W-1:0];
  end

  logic vld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld_r  <= valid_i;
      vld2_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r[0] <= res_nxt[0];
    res_r[1] <= res_nxt[1];
  end

  assign ctl_o = '{valid: vld2_r, dead: 1'b0};
  assign x_o   = res_r[0];
  assign y_o   = res_r[1];

endmodule

>>> src/nfc_div.sv
// ----------------------------------------------------------------------------
// nfc_div
// Pipelined restoring divider for the two Newton step quotients, sharing
// one denominator. One overflow check stage, one quotient bit per stage,
// one sign and saturation stage. Carries x and y alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfc_div #(
  parameter int FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nfc_pkg::nfc_ctl_t             ctl_i,
  input  logic [2*FRAC_BITS+8:0]        den_i,
  input  logic [2*FRAC_BITS+8:0]        mre_i,
  input  logic [2*FRAC_BITS+8:0]        mim_i,
  input  logic                          neg_re_i,
  input  logic                          neg_im_i,
  input  logic signed [FRAC_BITS+3:0]   x_i,
  input  logic signed [FRAC_BITS+3:0]   y_i,
  output nfc_pkg::nfc_ctl_t             ctl_o,
  output logic signed [FRAC_BITS+3:0]   qre_o,
  output logic signed [FRAC_BITS+3:0]   qim_o,
  output logic signed [FRAC_BITS+3:0]   x_o,
  output logic signed [FRAC_BITS+3:0]   y_o
);

  localparam int W  = FRAC_BITS + 4;
  localparam int SW = 2 * W + 1;
  localparam int MW = SW + FRAC_BITS;
  localparam int CW = SW + W + FRAC_BITS;
  localparam logic [W-1:0]        QLIM = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // slot W is the overflow stage, slot k holds bits down to k
  nfc_pkg::nfc_ctl_t   ctl_r  [W+1];
  logic [SW-1:0]       den_r  [W+1];
  logic [MW-1:0]       rre_r  [W+1];
  logic [MW-1:0]       rim_r  [W+1];
  logic [W-1:0]        qre_r  [W+1];
  logic [W-1:0]        qim_r  [W+1];
  logic [1:0]          ovf_r  [W+1];
  logic [1:0]          neg_r  [W+1];
  logic signed [W-1:0] x_r    [W+1];
  logic signed [W-1:0] y_r    [W+1];

  // overflow stage: quotient at or above 2^W saturates
  logic [MW-1:0] mre, mim;
  logic [CW-1:0] dtop;
  logic [1:0]    ovf_nxt;

  assign mre     = {mre_i, {FRAC_BITS{1'b0}}};
  assign mim     = {mim_i, {FRAC_BITS{1'b0}}};
  assign dtop    = CW'({den_i, {W{1'b0}}});
  assign ovf_nxt = {CW'(mim) >= dtop, CW'(mre) >= dtop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[W] <= '0;
    end else begin
      ctl_r[W] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    den_r[W] <= den_i;
    rre_r[W] <= mre;
    rim_r[W] <= mim;
    qre_r[W] <= '0;
    qim_r[W] <= '0;
    ovf_r[W] <= ovf_nxt;
    neg_r[W] <= {neg_im_i, neg_re_i};
    x_r[W]   <= x_i;
    y_r[W]   <= y_i;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < W; k++) begin : g_bit
    logic [CW-1:0] dsh;
    logic          ge_re, ge_im;
    logic [MW-1:0] rre_nxt, rim_nxt;
    logic [W-1:0]  qre_nxt, qim_nxt;

    assign dsh     = CW'(den_r[k+1]) << k;
    assign ge_re   = CW'(rre_r[k+1]) >= dsh;
    assign ge_im   = CW'(rim_r[k+1]) >= dsh;
    assign rre_nxt = ge_re ? MW'(CW'(rre_r[k+1]) - dsh) : rre_r[k+1];
    assign rim_nxt = ge_im ? MW'(CW'(rim_r[k+1]) - dsh) : rim_r[k+1];
    assign qre_nxt = qre_r[k+1] | (W'(ge_re) << k);
    assign qim_nxt = qim_r[k+1] | (W'(ge_im) << k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_r[k+1];
      end
    end

    always_ff @(posedge clk) begin
      den_r[k] <= den_r[k+1];
      rre_r[k] <= rre_nxt;
      rim_r[k] <= rim_nxt;
      qre_r[k] <= qre_nxt;
      qim_r[k] <= qim_nxt;
      ovf_r[k] <= ovf_r[k+1];
      neg_r[k] <= neg_r[k+1];
      x_r[k]   <= x_r[k+1];
      y_r[k]   <= y_r[k+1];
    end
  end

  // sign and saturation
  function automatic logic signed [W-1:0] signed_q(input logic [W-1:0] q,
                                                   input logic ovf,
                                                   input logic neg);
    if (neg) begin
      if (ovf || (q > QLIM)) return VMIN;
      return $signed(W'(~q + W'(1)));
    end
    if (ovf || q[W-1]) return VMAX;
    return $signed(q);
  endfunction

  nfc_pkg::nfc_ctl_t   ctl_out_r;
  logic signed [W-1:0] qre_out_r, qim_out_r, x_out_r, y_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_out_r <= '0;
    end else begin
      ctl_out_r <= ctl_r[0];
    end
  end

  always_ff @(posedge clk) begin
    qre_out_r <= signed_q(qre_r[0], ovf_r[0][0], neg_r[0][0]);
    qim_out_r <= signed_q(qim_r[0], ovf_r[0][1], neg_r[0][1]);
    x_out_r   <= x_r[0];
    y_out_r   <= y_r[0];
  end

  assign ctl_o = ctl_out_r;
  assign qre_o = qre_out_r;
  assign qim_o = qim_out_r;
  assign x_o   = x_out_r;
  assign y_o   = y_out_r;

endmodule

>>> src/nfc_iter.sv
// ----------------------------------------------------------------------------
// nfc_iter
// One Newton step z - (z^3 - 1) / (3 z^2), fully pipelined:
// seven arithmetic stages, the divider, and the final update stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfc_iter #(
  parameter int FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nfc_pkg::nfc_ctl_t             ctl_i,
  input  logic signed [FRAC_BITS+3:0]   x_i,
  input  logic signed [FRAC_BITS+3:0]   y_i,
  output nfc_pkg::nfc_ctl_t             ctl_o,
  output logic signed [FRAC_BITS+3:0]   x_o,
  output logic signed [FRAC_BITS+3:0]   y_o
);

`include "newton_fractal_cubic_pixel_unit_assert.svh"

  localparam int W  = FRAC_BITS + 4;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int RW = PW + 1 - FRAC_BITS;
  localparam int ITER_LAT = W + 10;
  localparam logic signed [RW-1:0] SMAX = RW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);
  localparam logic signed [PW:0]   HALF = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [W-1:0]  ONE  = W'(1) << FRAC_BITS;

  function automatic logic signed [W-1:0] sat_w(input logic signed [RW-1:0] v);
    if (v > SMAX) return {1'b0, {(W-1){1'b1}}};
    if (v < SMIN) return {1'b1, {(W-1){1'b0}}};
    return v[W-1:0];
  endfunction

  // product rounded half up to FRAC_BITS fraction bits, saturated
  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [PW:0] p;
    logic signed [PW:0] s;
    p = (PW+1)'(a) * (PW+1)'(b) + HALF;
    s = p >>> FRAC_BITS;
    return sat_w(s[RW-1:0]);
  endfunction

  nfc_pkg::nfc_ctl_t ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r, ctl_e_r, ctl_f_r, ctl_g_r;
  nfc_pkg::nfc_ctl_t ctl_h_r, ctl_div;
  logic              dead_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
      ctl_e_r <= '0;
      ctl_f_r <= '0;
      ctl_g_r <= '0;
      ctl_h_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
      ctl_e_r <= '{valid: ctl_d_r.valid, dead: dead_nxt};
      ctl_f_r <= ctl_e_r;
      ctl_g_r <= ctl_f_r;
      ctl_h_r <= ctl_div;
    end
  end

  // stage A: z squared products
  logic signed [W-1:0] x_a_r, y_a_r, xx_a_r, yy_a_r, xy_a_r;

  always_ff @(posedge clk) begin
    x_a_r  <= x_i;
    y_a_r  <= y_i;
    xx_a_r <= fmul(x_i, x_i);
    yy_a_r <= fmul(y_i, y_i);
    xy_a_r <= fmul(x_i, y_i);
  end

  // stage B: z^2 and 3 z^2
  logic signed [W-1:0] r2_nxt, i2_nxt, c_nxt, d_nxt;
  logic signed [W-1:0] x_b_r, y_b_r, r2_b_r, i2_b_r, c_b_r, d_b_r;

  assign r2_nxt = sat_w(RW'(xx_a_r) - RW'(yy_a_r));
  assign i2_nxt = sat_w(RW'(xy_a_r) + RW'(xy_a_r));
  assign c_nxt  = sat_w(RW'(r2_nxt) + RW'(r2_nxt) + RW'(r2_nxt));
  assign d_nxt  = sat_w(RW'(i2_nxt) + RW'(i2_nxt) + RW'(i2_nxt));

  always_ff @(posedge clk) begin
    x_b_r  <= x_a_r;
    y_b_r  <= y_a_r;
    r2_b_r <= r2_nxt;
    i2_b_r <= i2_nxt;
    c_b_r  <= c_nxt;
    d_b_r  <= d_nxt;
  end

  // stage C: z cubed products
  logic signed [W-1:0] x_c_r, y_c_r, c_c_r, d_c_r, p1_c_r, p2_c_r, p3_c_r, p4_c_r;

  always_ff @(posedge clk) begin
    x_c_r  <= x_b_r;
    y_c_r  <= y_b_r;
    c_c_r  <= c_b_r;
    d_c_r  <= d_b_r;
    p1_c_r <= fmul(r2_b_r, x_b_r);
    p2_c_r <= fmul(i2_b_r, y_b_r);
    p3_c_r <= fmul(r2_b_r, y_b_r);
    p4_c_r <= fmul(i2_b_r, x_b_r);
  end

  // stage D: numerator z^3 - 1
  logic signed [W-1:0] r3_nxt, a_nxt, b_nxt;
  logic signed [W-1:0] x_d_r, y_d_r, a_d_r, b_d_r, c_d_r, d_d_r;

  assign r3_nxt = sat_w(RW'(p1_c_r) - RW'(p2_c_r));
  assign b_nxt  = sat_w(RW'(p3_c_r) + RW'(p4_c_r));
  assign a_nxt  = sat_w(RW'(r3_nxt) - RW'(ONE));

  always_ff @(posedge clk) begin
    x_d_r <= x_c_r;
    y_d_r <= y_c_r;
    a_d_r <= a_nxt;
    b_d_r <= b_nxt;
    c_d_r <= c_c_r;
    d_d_r <= d_c_r;
  end

  // stage E: wide products for n * conj(d) and |d|^2
  logic signed [PW-1:0] cc_nxt, dd_nxt, ac_nxt, bd_nxt, bc_nxt, ad_nxt;
  logic signed [W-1:0]  x_e_r, y_e_r;
  logic signed [PW-1:0] cc_e_r, dd_e_r, ac_e_r, bd_e_r, bc_e_r, ad_e_r;

  assign dead_nxt = ctl_d_r.dead || ((c_d_r == '0) && (d_d_r == '0));
  assign cc_nxt   = PW'(c_d_r) * PW'(c_d_r);
  assign dd_nxt   = PW'(d_d_r) * PW'(d_d_r);
  assign ac_nxt   = PW'(a_d_r) * PW'(c_d_r);
  assign bd_nxt   = PW'(b_d_r) * PW'(d_d_r);
  assign bc_nxt   = PW'(b_d_r) * PW'(c_d_r);
  assign ad_nxt   = PW'(a_d_r) * PW'(d_d_r);

  always_ff @(posedge clk) begin
    x_e_r  <= x_d_r;
    y_e_r  <= y_d_r;
    cc_e_r <= cc_nxt;
    dd_e_r <= dd_nxt;
    ac_e_r <= ac_nxt;
    bd_e_r <= bd_nxt;
    bc_e_r <= bc_nxt;
    ad_e_r <= ad_nxt;
  end

  // stage F: denominator and numerator sums
  logic signed [W-1:0]  x_f_r, y_f_r;
  logic signed [SW-1:0] den_f_r, nre_f_r, nim_f_r;

  always_ff @(posedge clk) begin
    x_f_r   <= x_e_r;
    y_f_r   <= y_e_r;
    den_f_r <= SW'(cc_e_r) + SW'(dd_e_r);
    nre_f_r <= SW'(ac_e_r) + SW'(bd_e_r);
    nim_f_r <= SW'(bc_e_r) - SW'(ad_e_r);
  end

  // stage G: magnitudes and signs for the divider
  logic signed [W-1:0] x_g_r, y_g_r;
  logic [SW-1:0]       den_g_r, mre_g_r, mim_g_r;
  logic                nre_neg_g_r, nim_neg_g_r;

  always_ff @(posedge clk) begin
    x_g_r       <= x_f_r;
    y_g_r       <= y_f_r;
    den_g_r     <= den_f_r;
    mre_g_r     <= nre_f_r[SW-1] ? SW'(-nre_f_r) : SW'(nre_f_r);
    mim_g_r     <= nim_f_r[SW-1] ? SW'(-nim_f_r) : SW'(nim_f_r);
    nre_neg_g_r <= nre_f_r[SW-1];
    nim_neg_g_r <= nim_f_r[SW-1];
  end

  logic signed [W-1:0] qre, qim, x_q, y_q;

  nfc_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_g_r),
    .den_i    (den_g_r),
    .mre_i    (mre_g_r),
    .mim_i    (mim_g_r),
    .neg_re_i (nre_neg_g_r),
    .neg_im_i (nim_neg_g_r),
    .x_i      (x_g_r),
    .y_i      (y_g_r),
    .ctl_o    (ctl_div),
    .qre_o    (qre),
    .qim_o    (qim),
    .x_o      (x_q),
    .y_o      (y_q)
  );

  // stage H: update z
  logic signed [W-1:0] x_h_r, y_h_r;

  always_ff @(posedge clk) begin
    x_h_r <= sat_w(RW'(x_q) - RW'(qre));
    y_h_r <= sat_w(RW'(y_q) - RW'(qim));
  end

  assign ctl_o = ctl_h_r;
  assign x_o   = x_h_r;
  assign y_o   = y_h_r;

  // a pixel once dead stays dead through the step
  `NFC_ASSERT_IMPL(a_dead_kept, clk, rst_n, $past(ctl_i.dead, ITER_LAT), ctl_o.dead, "dead lost")
  // every valid output traces back to a valid input of the step
  `NFC_ASSERT_IMPL(a_valid_lat, clk, rst_n, ctl_o.valid, $past(ctl_i.valid, ITER_LAT), "no input")

endmodule

>>> src/nfc_classify.sv
// ----------------------------------------------------------------------------
// nfc_classify
// Picks the nearest cube root of unity by exact comparison of y^2 with
// 3 x^2 and the signs of x and y (dead pixels take root 0), then forms the color. Two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfc_classify #(
  parameter int FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nfc_pkg::nfc_ctl_t             ctl_i,
  input  logic signed [FRAC_BITS+3:0]   x_i,
  input  logic signed [FRAC_BITS+3:0]   y_i,
  output logic                          valid_o,
  output logic [1:0]                    root_o,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o
);

`include "newton_fractal_cubic_pixel_unit_assert.svh"

  localparam int W  = FRAC_BITS + 4;
  localparam int PW = 2 * W;
  localparam int XW = PW + 2;

  // stage 1: squares and sign flags
  nfc_pkg::nfc_ctl_t ctl1_r;
  logic [PW-1:0]     uu_r, xx_r;
  logic              x_neg_r, y_neg_r, y_zero_r;
  logic signed [PW-1:0] uu_nxt, xx_nxt;

  assign uu_nxt = PW'(y_i) * PW'(y_i);
  assign xx_nxt = PW'(x_i) * PW'(x_i);

  always_ff @(posedge clk) begin
    uu_r     <= uu_nxt;
    xx_r     <= xx_nxt;
    x_neg_r  <= x_i[W-1];
    y_neg_r  <= y_i[W-1];
    y_zero_r <= (y_i == '0);
  end

  // stage 2: compares and root choice
  logic [XW-1:0] x3, uu_ext;
  logic          lt_ux, lt_xu, y_le0, above_up, above_dn;
  logic [1:0]    root_nxt;

  assign x3       = XW'(xx_r) + (XW'(xx_r) << 1);
  assign uu_ext   = XW'(uu_r);
  assign lt_ux    = uu_ext < x3;
  assign lt_xu    = x3 < uu_ext;
  assign y_le0    = y_neg_r || y_zero_r;
  // y above the line through root 1, and -y above it
  assign above_up = x_neg_r ? (!y_neg_r || lt_ux) : (!y_le0 && lt_xu);
  assign above_dn = x_neg_r ? (y_le0 || lt_ux) : (y_neg_r && lt_xu);

  always_comb begin
    if (ctl1_r.dead) begin
      root_nxt = nfc_pkg::ROOT_ONE;
    end else if (above_up) begin
      root_nxt = y_neg_r ? nfc_pkg::ROOT_DN : nfc_pkg::ROOT_UP;
    end else if (above_dn) begin
      root_nxt = nfc_pkg::ROOT_DN;
    end else begin
      root_nxt = nfc_pkg::ROOT_ONE;
    end
  end

  logic       vld_r;
  logic [1:0] root_r;
  logic [7:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      ctl1_r <= ctl_i;
      vld_r  <= ctl1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    root_r  <= root_nxt;
    red_r   <= (root_nxt == nfc_pkg::ROOT_ONE) ? nfc_pkg::COLOR_FULL : nfc_pkg::COLOR_NONE;
    green_r <= (root_nxt == nfc_pkg::ROOT_UP)  ? nfc_pkg::COLOR_FULL : nfc_pkg::COLOR_NONE;
    blue_r  <= (root_nxt == nfc_pkg::ROOT_DN)  ? nfc_pkg::COLOR_FULL : nfc_pkg::COLOR_NONE;
  end

  assign valid_o = vld_r;
  assign root_o  = root_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;

  // zero derivative forces root 0
  logic dead_in, dead_ok;

  assign dead_in = ctl1_r.valid && ctl1_r.dead;
  assign dead_ok = valid_o && (root_o == nfc_pkg::ROOT_ONE);

  `NFC_ASSERT_NEXT(a_dead_root, clk, rst_n, dead_in, dead_ok, "dead pixel not on root 0")

endmodule

>>> src/newton_fractal_cubic_pixel_unit.sv
// Throughput: one pixel per cycle; every stage is registered and busy stays low.
// Each Newton step holds a divider with FRAC_BITS+4 stages of one quotient bit each.
// Reset (synchronous, rst_n low) clears all valid bits and loads the register defaults.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// newton_fractal_cubic_pixel_unit
// Newton fractal pixel for z^3 - 1: plane mapping, unrolled Newton steps
// and root coloring, one deep pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module newton_fractal_cubic_pixel_unit #(
  parameter int ITERATIONS = 5,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [COORD_BITS-1:0]             in_x_coord,
  input  logic [COORD_BITS-1:0]             in_y_coord,
  output logic                              out_valid,
  output logic [1:0]                        out_root_index,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

`include "newton_fractal_cubic_pixel_unit_assert.svh"

  localparam int W   = FRAC_BITS + 4;
  localparam int LAT = 4 + ITERATIONS * (FRAC_BITS + 14);

  // configuration registers
  logic signed [nfc_pkg::ORIGIN_W-1:0] origin_r;
  logic [nfc_pkg::STEP_W-1:0]          step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= nfc_pkg::ORIGIN_RST;
      step_r   <= nfc_pkg::STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nfc_pkg::CFG_ORIGIN: origin_r <= $signed(cfg_data);
        nfc_pkg::CFG_STEP:   step_r   <= cfg_data[nfc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // coordinate mapping
  nfc_pkg::nfc_ctl_t   it_ctl [ITERATIONS+1];
  logic signed [W-1:0] it_x   [ITERATIONS+1];
  logic signed [W-1:0] it_y   [ITERATIONS+1];

  nfc_map #(
    .FRAC_BITS (FRAC_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (start && !busy),
    .x_coord_i (in_x_coord),
    .y_coord_i (in_y_coord),
    .origin_i  (origin_r),
    .step_i    (step_r),
    .ctl_o     (it_ctl[0]),
    .x_o       (it_x[0]),
    .y_o       (it_y[0])
  );

  // unrolled Newton steps
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
    nfc_iter #(
      .FRAC_BITS(FRAC_BITS)
    ) u_iter (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (it_ctl[k]),
      .x_i   (it_x[k]),
      .y_i   (it_y[k]),
      .ctl_o (it_ctl[k+1]),
      .x_o   (it_x[k+1]),
      .y_o   (it_y[k+1])
    );
  end

  nfc_classify #(
    .FRAC_BITS(FRAC_BITS)
  ) u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (it_ctl[ITERATIONS]),
    .x_i     (it_x[ITERATIONS]),
    .y_i     (it_y[ITERATIONS]),
    .valid_o (out_valid),
    .root_o  (out_root_index),
    .red_o   (out_red),
    .green_o (out_green),
    .blue_o  (out_blue)
  );

  // checker terms
  logic       req_acc;
  logic [2:0] lit;

  assign req_acc = start && !busy;
  assign lit     = {out_red == nfc_pkg::COLOR_FULL, out_green == nfc_pkg::COLOR_FULL,
                    out_blue == nfc_pkg::COLOR_FULL};

  // each result answers an earlier accepted request
  `NFC_ASSERT_IMPL(a_out_lat, clk, rst_n, out_valid, $past(req_acc, LAT), "result without request")
  // exactly one color channel lit, and a legal root code
  `NFC_ASSERT_IMPL(a_color, clk, rst_n, out_valid, $onehot(lit) && (out_root_index <= nfc_pkg::ROOT_DN), "bad color")

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Newton fractal pixel unit testbench
// Drives pixel requests under several plane origin and step settings and
// checks each root index and color against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected root and colors of one pixel
typedef struct {
  logic [1:0] root;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
} pixel_color_t;

class pixel_scoreboard;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint ONE  = 64'sd268435456;
  localparam int     NEWTON_STEPS = 5;

  longint       plane_origin;
  longint       plane_step;
  pixel_color_t pending_pixels[$];
  int           mismatches;

  function new();
    plane_origin = nfc_pkg::ORIGIN_RST;
    plane_step   = nfc_pkg::STEP_RST;
    mismatches   = 0;
  endfunction

  function void set_register(logic [nfc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    if (idx == nfc_pkg::CFG_ORIGIN) plane_origin = longint'($signed(data));
    else if (idx == nfc_pkg::CFG_STEP) plane_step = longint'(data[30:0]);
  endfunction

  function longint clamp(longint v);
    return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
  endfunction

  function longint clamp_wide(logic signed [127:0] v);
    logic signed [127:0] hi, lo;
    hi = VMAX;
    lo = VMIN;
    if (v > hi) return VMAX;
    if (v < lo) return VMIN;
    return longint'(v);
  endfunction

  // product rounded half up to Q4.28
  function longint qmul(longint a, longint b);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p = wa * wb + (128'sd1 <<< 27);
    return clamp_wide(p >>> 28);
  endfunction

  // (n << 28) / den truncated toward zero, den > 0
  function longint qdiv(logic signed [127:0] n, logic signed [127:0] den);
    logic [127:0] mag, d;
    logic signed [127:0] q;
    mag = (n < 0) ? -n : n;
    d = den;
    mag = (mag << 28) / d;
    q = mag;
    if (n < 0) q = -q;
    return clamp_wide(q);
  endfunction

  // u > sqrt(3) * x, exact
  function bit above_sqrt3(longint u, longint x);
    logic signed [127:0] wu, wx, uu, x3;
    wu = u;
    wx = x;
    uu = wu * wu;
    x3 = 3 * wx * wx;
    if (x < 0) return (u >= 0) ? 1'b1 : (uu < x3);
    if (u <= 0) return 1'b0;
    return x3 < uu;
  endfunction

  function longint plane_coord(logic [11:0] c);
    return clamp(plane_origin + plane_step * longint'(c));
  endfunction

  function pixel_color_t predict_pixel(logic [11:0] xc, logic [11:0] yc);
    longint x, y, xy, r2, i2, r3, i3, a, b, c, d;
    logic signed [127:0] wa, wb, wc, wd, den, nre, nim;
    bit dead;
    logic [1:0] root;
    pixel_color_t px;
    x = plane_coord(xc);
    y = plane_coord(yc);
    dead = 0;
    for (int k = 0; k < NEWTON_STEPS; k++) begin
      xy = qmul(x, y);
      r2 = clamp(qmul(x, x) - qmul(y, y));
      i2 = clamp(xy + xy);
      r3 = clamp(qmul(r2, x) - qmul(i2, y));
      i3 = clamp(qmul(r2, y) + qmul(i2, x));
      a = clamp(r3 - ONE);
      b = i3;
      c = clamp(r2 * 3);
      d = clamp(i2 * 3);
      if (c == 0 && d == 0) begin
        dead = 1;
        break;
      end
      wa = a; wb = b; wc = c; wd = d;
      den = wc * wc + wd * wd;
      nre = wa * wc + wb * wd;
      nim = wb * wc - wa * wd;
      x = clamp(x - qdiv(nre, den));
      y = clamp(y - qdiv(nim, den));
    end
    root = nfc_pkg::ROOT_ONE;
    if (!dead) begin
      if (above_sqrt3(y, x)) root = nfc_pkg::ROOT_UP;
      if (root == nfc_pkg::ROOT_ONE ? above_sqrt3(-y, x) : (y < 0)) root = nfc_pkg::ROOT_DN;
    end
    px.root  = root;
    px.red   = (root == nfc_pkg::ROOT_ONE) ? nfc_pkg::COLOR_FULL : nfc_pkg::COLOR_NONE;
    px.green = (root == nfc_pkg::ROOT_UP)  ? nfc_pkg::COLOR_FULL : nfc_pkg::COLOR_NONE;
    px.blue  = (root == nfc_pkg::ROOT_DN)  ? nfc_pkg::COLOR_FULL : nfc_pkg::COLOR_NONE;
    return px;
  endfunction

  function void note_request(logic [11:0] xc, logic [11:0] yc);
    pending_pixels.push_back(predict_pixel(xc, yc));
  endfunction

  function void check_result(logic [1:0] root, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_color_t px;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result root=%0d", root);
      return;
    end
    px = pending_pixels.pop_front();
    if (px.root !== root || px.red !== r || px.green !== g || px.blue !== b) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: exp root=%0d rgb=%h/%h/%h got root=%0d rgb=%h/%h/%h",
                 px.root, px.red, px.green, px.blue, root, r, g, b);
    end
  endfunction
endclass

module tb_top;
  localparam int LATENCY = 214;
  localparam int LIMIT   = 400000;

  logic        clk, rst_n, start, busy;
  logic [11:0] in_x_coord, in_y_coord;
  logic        out_valid;
  logic [1:0]  out_root_index;
  logic [7:0]  out_red, out_green, out_blue;
  logic        cfg_valid, cfg_ready;
  logic [nfc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  pixel_scoreboard sb;
  int  cycles;
  bit  no_idle;

  newton_fractal_cubic_pixel_unit u_dut (
    .clk, .rst_n, .start, .busy, .in_x_coord, .in_y_coord,
    .out_valid, .out_root_index, .out_red, .out_green, .out_blue,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("newton_fractal_cubic_pixel_unit: mismatch");
      $finish;
    end
  end

  // monitors: requests, results and register writes
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_request(in_x_coord, in_y_coord);
    if (rst_n && out_valid) sb.check_result(out_root_index, out_red, out_green, out_blue);
    if (rst_n && cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
  end

  // start stays high between back-to-back requests; callers drop it when done
  task automatic send_pixel(logic [11:0] xc, logic [11:0] yc);
    while (!no_idle && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_x_coord <= xc;
    in_y_coord <= yc;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // waits out the pipeline, then writes one register
  task automatic write_reg(logic [nfc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    start <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly near the picture, sometimes anywhere
  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_pixel(12'($urandom), 12'($urandom));
      else send_pixel(12'($urandom_range(1023)), 12'($urandom_range(1023)));
    end
  endtask

  initial begin
    logic [11:0] edges[4] = '{12'd0, 12'd1, 12'd2048, 12'd4095};
    sb = new();
    cycles = 0;
    no_idle = 0;
    rst_n = 0;
    start = 0;
    in_x_coord = '0;
    in_y_coord = '0;
    cfg_valid = 0;
    cfg_index = nfc_pkg::CFG_ORIGIN;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes at reset settings
    foreach (edges[i]) foreach (edges[j]) send_pixel(edges[i], edges[j]);

    // zero derivative: start exactly at the origin
    write_reg(nfc_pkg::CFG_ORIGIN, 32'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    // unused indexes must be ignored
    write_reg(2'd2, 32'hDEAD_BEEF);
    write_reg(2'd3, 32'h1234_5678);
    send_pixel(12'd0, 12'd0);

    // register extremes
    write_reg(nfc_pkg::CFG_ORIGIN, 32'h8000_0000);
    write_reg(nfc_pkg::CFG_STEP, 32'h7FFF_FFFF);
    random_pixels(60);
    write_reg(nfc_pkg::CFG_ORIGIN, 32'h7FFF_FFFF);
    write_reg(nfc_pkg::CFG_STEP, 32'd0);
    random_pixels(20);
    write_reg(nfc_pkg::CFG_STEP, 32'hFFFF_FFFF);
    random_pixels(40);

    // picture-sized windows, one phase without any idling
    write_reg(nfc_pkg::CFG_ORIGIN, -32'sd402653184);
    write_reg(nfc_pkg::CFG_STEP, 32'd786432);
    no_idle = 1;
    random_pixels(400);
    no_idle = 0;
    write_reg(nfc_pkg::CFG_ORIGIN, -32'sd268435456);
    write_reg(nfc_pkg::CFG_STEP, 32'd524288);
    random_pixels(400);

    // random settings
    for (int p = 0; p < 6; p++) begin
      write_reg(nfc_pkg::CFG_ORIGIN, -32'($urandom_range(600000000)));
      write_reg(nfc_pkg::CFG_STEP, $urandom_range(1200000));
      random_pixels(90);
    end

    // drain and finish
    start <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
      $display("newton_fractal_cubic_pixel_unit: match");
    else
      $display("newton_fractal_cubic_pixel_unit: mismatch");
    $finish;
  end
endmodule
